/* rtl/lfuc_pkg.sv */
// Shared constants, types and state encoding of the LFU key/value store.
`default_nettype none

package lfuc_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int COUNT_BITS_DEF  = 16;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	// wide enough for any entry count up to 256 and any capacity code
	localparam int CMP_W = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_RESP
	} lfuc_state_t;

	// storage strobes for one cycle
	typedef struct packed {
		logic scan_re;
		logic val_re;
		logic val_we;
		logic ent_we;
		logic rank_we;
	} store_ctl_t;

	// what the scan found so far
	typedef struct packed {
		logic found;
		logic victim;
		logic vacant;
	} pick_flags_t;

endpackage

`default_nettype wire

/* rtl/lfuc_if.sv */
// Request and response channel interfaces of the LFU key/value store.
`default_nettype none

interface lfuc_req_if import lfuc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;

	modport source (output valid, opcode, key, value, input ready);
	modport sink (input valid, opcode, key, value, output ready);
endinterface

interface lfuc_rsp_if import lfuc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [VAL_W-1:0] read_value;
	logic             evicted;
	logic [KEY_W-1:0] evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

/* rtl/lfuc_store.sv */
// Entry storage: key, value, use count and recency rank memories plus valid flags.
`default_nettype none

module lfuc_store import lfuc_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire store_ctl_t            ctl,
	input  wire logic [AW-1:0]         scan_addr,
	input  wire logic [AW-1:0]         ent_addr,
	input  wire logic [AW-1:0]         rank_waddr,
	input  wire logic [KEY_W-1:0]      key_w,
	input  wire logic [COUNT_BITS-1:0] cnt_w,
	input  wire logic [VAL_W-1:0]      val_w,
	input  wire logic [AW-1:0]         rank_w,
	output logic                       scan_valid_q,
	output logic [KEY_W-1:0]           scan_key_q,
	output logic [COUNT_BITS-1:0]      scan_cnt_q,
	output logic [AW-1:0]              scan_rank_q,
	output logic [VAL_W-1:0]           val_rd_q
);

	logic [KEY_W-1:0]      key_mem   [MAX_ENTRIES];
	logic [VAL_W-1:0]      val_mem   [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem   [MAX_ENTRIES];
	logic [AW-1:0]         rank_mem  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			scan_valid_q <= 1'b0;
		end else begin
			if (ctl.ent_we) begin
				valid_q[ent_addr] <= 1'b1;
			end
			if (ctl.scan_re) begin
				scan_valid_q <= valid_q[scan_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ent_we) begin
			key_mem[ent_addr] <= key_w;
			cnt_mem[ent_addr] <= cnt_w;
		end
		if (ctl.scan_re) begin
			scan_key_q  <= key_mem[scan_addr];
			scan_cnt_q  <= cnt_mem[scan_addr];
			scan_rank_q <= rank_mem[scan_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rank_we) begin
			rank_mem[rank_waddr] <= rank_w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[ent_addr] <= val_w;
		end
		if (ctl.val_re) begin
			val_rd_q <= val_mem[ent_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/lfuc_pick.sv */
// Shared compare unit: folds one entry per cycle into key match, victim and free slot.
`default_nettype none

module lfuc_pick import lfuc_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  clr,
	input  wire logic                  dv,
	input  wire logic [AW-1:0]         tag,
	input  wire logic                  ent_valid,
	input  wire logic [KEY_W-1:0]      ent_key,
	input  wire logic [COUNT_BITS-1:0] ent_cnt,
	input  wire logic [AW-1:0]         ent_rank,
	input  wire logic [KEY_W-1:0]      key,
	output pick_flags_t                flags_q,
	output logic [AW-1:0]              found_idx_q,
	output logic [COUNT_BITS-1:0]      found_cnt_q,
	output logic [AW-1:0]              found_rank_q,
	output logic [AW-1:0]              vic_idx_q,
	output logic [AW-1:0]              vic_rank_q,
	output logic [KEY_W-1:0]           vic_key_q,
	output logic [AW-1:0]              free_idx_q
);

	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic                  take_found;
	logic                  take_vic;
	logic                  take_free;

	always_comb begin
		take_found = dv && ent_valid && (ent_key == key) && !flags_q.found;
		// lowest count wins; among equal counts the oldest
		take_vic   = dv && ent_valid && (!flags_q.victim || (ent_cnt < vic_cnt_q) ||
			((ent_cnt == vic_cnt_q) && (ent_rank > vic_rank_q)));
		take_free  = dv && !ent_valid && !flags_q.vacant;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else begin
			if (take_found) flags_q.found  <= 1'b1;
			if (take_vic)   flags_q.victim <= 1'b1;
			if (take_free)  flags_q.vacant <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_found) begin
			found_idx_q  <= tag;
			found_cnt_q  <= ent_cnt;
			found_rank_q <= ent_rank;
		end
		if (take_vic) begin
			vic_idx_q  <= tag;
			vic_cnt_q  <= ent_cnt;
			vic_rank_q <= ent_rank;
			vic_key_q  <= ent_key;
		end
		if (take_free) begin
			free_idx_q <= tag;
		end
	end

endmodule

`default_nettype wire

/* rtl/lfu_cache_lru_tiebreak_unit.sv */
// Top level of the LFU key/value store with least-recently-used tie-break.
//
// Usage:
//   req  - request channel (valid/ready): opcode (get or put), key, value.
//   rsp  - response channel (valid/ready): hit, read_value, evicted, evicted_key.
//          Exactly one response item per request item, in order.
//   cfg_we / cfg_wdata - capacity register; write only while the block is idle.
//          Values above MAX_ENTRIES act as MAX_ENTRIES; zero turns puts into no-ops.
// Sequence: the block takes one item at a time. A scan of all MAX_ENTRIES
//   entries through the single compare unit comes first, a decision state
//   follows, and an item that touches or inserts an entry then sweeps the rank
//   memory once more through the same read port before the response state;
//   req.ready returns the cycle after the response loads.
// Reset clears all valid flags, the occupancy and the response valid flag and sets
//   capacity to 16; key, value, count and rank memories need no clearing.
// A stalled receiver holds the response in its output register; the next item is
//   taken meanwhile, and its response waits in the final state until the slot frees.
`default_nettype none

module lfu_cache_lru_tiebreak_unit import lfuc_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	lfuc_req_if.sink              req,
	lfuc_rsp_if.source            rsp
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0]         LAST_CNT = CW'(MAX_ENTRIES);
	localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

	lfuc_state_t state_q, state_d;

	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    occupancy_q;
	logic [CW-1:0]    cnt_q;
	logic             dv_s1;
	logic [AW-1:0]    tag_s1;

	// latched item
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// update plan from the decision cycle
	logic [AW-1:0]    slot_q;
	logic [AW-1:0]    rref_q;
	logic             all_q;

	// response being built
	logic             res_hit_q;
	logic             res_evict_q;
	logic [KEY_W-1:0] res_ekey_q;
	logic             res_get_q;

	// response register
	logic             rsp_valid_q;
	logic             rsp_hit_q;
	logic [VAL_W-1:0] rsp_value_q;
	logic             rsp_evict_q;
	logic [KEY_W-1:0] rsp_ekey_q;

	logic accept;
	logic issue;
	logic scan_done;
	logic rsp_load;

	store_ctl_t            ctl;
	logic [AW-1:0]         ent_addr;
	logic [COUNT_BITS-1:0] cnt_w;
	logic                  rank_hit;
	logic [AW-1:0]         rank_w;

	logic                  scan_valid;
	logic [KEY_W-1:0]      scan_key;
	logic [COUNT_BITS-1:0] scan_cnt;
	logic [AW-1:0]         scan_rank;
	logic [VAL_W-1:0]      val_rd;

	pick_flags_t           flags;
	logic [AW-1:0]         found_idx;
	logic [COUNT_BITS-1:0] found_cnt;
	logic [AW-1:0]         found_rank;
	logic [AW-1:0]         vic_idx;
	logic [AW-1:0]         vic_rank;
	logic [KEY_W-1:0]      vic_key;
	logic [AW-1:0]         free_idx;

	// decision terms
	logic [CMP_W-1:0] cap_w;
	logic [CMP_W-1:0] occ_w;
	logic             cap_zero;
	logic             use_vic;
	logic             use_free;
	logic             do_touch;
	logic             do_ins;
	logic [AW-1:0]    slot_d;

	lfuc_store #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.scan_addr   (cnt_q[AW-1:0]),
		.ent_addr    (ent_addr),
		.rank_waddr  (tag_s1),
		.key_w       (key_q),
		.cnt_w       (cnt_w),
		.val_w       (val_q),
		.rank_w      (rank_w),
		.scan_valid_q(scan_valid),
		.scan_key_q  (scan_key),
		.scan_cnt_q  (scan_cnt),
		.scan_rank_q (scan_rank),
		.val_rd_q    (val_rd)
	);

	lfuc_pick #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (accept),
		.dv          (dv_s1 && (state_q == ST_SCAN)),
		.tag         (tag_s1),
		.ent_valid   (scan_valid),
		.ent_key     (scan_key),
		.ent_cnt     (scan_cnt),
		.ent_rank    (scan_rank),
		.key         (key_q),
		.flags_q     (flags),
		.found_idx_q (found_idx),
		.found_cnt_q (found_cnt),
		.found_rank_q(found_rank),
		.vic_idx_q   (vic_idx),
		.vic_rank_q  (vic_rank),
		.vic_key_q   (vic_key),
		.free_idx_q  (free_idx)
	);

	// Decide what the item does once the scan has seen every entry.
	always_comb begin
		if ({{(CMP_W-CAP_W){1'b0}}, capacity_q} > CMP_W'(MAX_ENTRIES)) begin
			cap_w = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_w = {{(CMP_W-CAP_W){1'b0}}, capacity_q};
		end
		occ_w    = CMP_W'(occupancy_q);
		cap_zero = (cap_w == '0);
		use_vic  = (occ_w >= cap_w) && flags.victim;
		use_free = !use_vic && flags.vacant;
		do_touch = flags.found && ((op_q == OP_GET) || !cap_zero);
		do_ins   = !flags.found && (op_q == OP_PUT) && !cap_zero && (use_vic || use_free);
		if (flags.found) begin
			slot_d = found_idx;
		end else if (use_vic) begin
			slot_d = vic_idx;
		end else begin
			slot_d = free_idx;
		end
	end

	assign accept    = req.valid && req.ready;
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (cnt_q != LAST_CNT);
	assign scan_done = (cnt_q == LAST_CNT) && !dv_s1;
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = (do_touch || do_ins) ? ST_UPDATE : ST_RESP;
			end
			ST_UPDATE: begin
				if (scan_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: storage strobes and write data.
	always_comb begin
		ctl          = '0;
		ent_addr     = slot_d;
		cnt_w        = CNT_ONE;
		rank_hit     = 1'b0;
		rank_w       = '0;
		req.ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_SCAN: begin
				ctl.scan_re = issue;
			end
			ST_DECIDE: begin
				// one write of key and count covers both touch and insert
				ctl.ent_we = do_touch || do_ins;
				ctl.val_we = (do_touch && (op_q == OP_PUT)) || do_ins;
				ctl.val_re = flags.found && (op_q == OP_GET);
				if (do_touch) begin
					cnt_w = (found_cnt == CNT_MAX) ? found_cnt : found_cnt + CNT_ONE;
				end
			end
			ST_UPDATE: begin
				ctl.scan_re = issue;
				// age entries newer than rref_q (all if all_q); target becomes newest
				rank_hit    = (tag_s1 == slot_q);
				ctl.rank_we = dv_s1 && scan_valid &&
					(rank_hit || all_q || (scan_rank < rref_q));
				rank_w      = rank_hit ? '0 : scan_rank + AW'(1);
			end
			ST_RESP: begin
				ctl = '0;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CAP_RESET;
			occupancy_q <= '0;
			cnt_q       <= '0;
			dv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			// advance the entry counter; restart it for each sweep
			if (accept || (state_q == ST_DECIDE)) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			dv_s1 <= issue;
			if ((state_q == ST_DECIDE) && do_ins && !use_vic) begin
				occupancy_q <= occupancy_q + CW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= cnt_q[AW-1:0];
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			val_q <= req.value;
		end
		if (state_q == ST_DECIDE) begin
			slot_q      <= slot_d;
			rref_q      <= flags.found ? found_rank : vic_rank;
			all_q       <= !flags.found && !use_vic;
			res_hit_q   <= flags.found;
			res_evict_q <= do_ins && use_vic;
			res_ekey_q  <= (do_ins && use_vic) ? vic_key : '0;
			res_get_q   <= flags.found && (op_q == OP_GET);
		end
		if (rsp_load) begin
			rsp_hit_q   <= res_hit_q;
			rsp_value_q <= res_get_q ? val_rd : '0;
			rsp_evict_q <= res_evict_q;
			rsp_ekey_q  <= res_ekey_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.evicted     = rsp_evict_q;
	assign rsp.evicted_key = rsp_ekey_q;

endmodule

`default_nettype wire
